FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the core RTL. Define NO_ASSERTIONS
// to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
// Property checked only while out of reset
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, prop, msg)
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg)
`endif
`endif

FILE: rtl/core/trop_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Core package
// Field widths, instruction and host operation codes, ALU function codes and
// the request/response types of the twelve-op RISC core.
// ---------------------------------------------------------------------------
package trop_pkg;

  // Field widths
  localparam int OPW   = 3;
  localparam int WAW   = 11;
  localparam int DW    = 32;
  localparam int RSW   = 5;
  localparam int STW   = 2;
  localparam int IMM_W = 18;
  localparam int SHW   = 13;

  // Storage sizes
  localparam int MEM_WORDS_DEF = 2048;
  localparam int REG_COUNT     = 32;
  localparam int RAW           = $clog2(REG_COUNT);

  // Host operations
  localparam logic [OPW-1:0] HOP_LOAD    = 3'd0;
  localparam logic [OPW-1:0] HOP_EXEC    = 3'd1;
  localparam logic [OPW-1:0] HOP_RDMEM   = 3'd2;
  localparam logic [OPW-1:0] HOP_RDREG   = 3'd3;
  localparam logic [OPW-1:0] HOP_RESTART = 3'd4;

  // Result status
  localparam logic [STW-1:0] ST_OK     = 2'd0;
  localparam logic [STW-1:0] ST_HALTED = 2'd1;
  localparam logic [STW-1:0] ST_WRAP   = 2'd2;

  // Instruction opcodes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MULI = 4'd2;
  localparam logic [3:0] OP_ADDI = 4'd3;
  localparam logic [3:0] OP_BNE  = 4'd4;
  localparam logic [3:0] OP_ANDI = 4'd5;
  localparam logic [3:0] OP_ORI  = 4'd6;
  localparam logic [3:0] OP_J    = 4'd7;
  localparam logic [3:0] OP_SLL  = 4'd8;
  localparam logic [3:0] OP_SRL  = 4'd9;
  localparam logic [3:0] OP_LW   = 4'd10;
  localparam logic [3:0] OP_SW   = 4'd11;

  // Shared ALU functions
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_INC = 3'd2;
  localparam logic [2:0] ALU_MUL = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_OR  = 3'd5;
  localparam logic [2:0] ALU_SLL = 3'd6;
  localparam logic [2:0] ALU_SRL = 3'd7;

  typedef struct packed {
    logic [2:0]    fn;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [OPW-1:0] operation;
    logic [WAW-1:0] word_address;
    logic [DW-1:0]  load_value;
    logic [RSW-1:0] register_select;
  } in_req_t;

  typedef struct packed {
    logic [STW-1:0] status;
    logic [WAW-1:0] executed_pc;
    logic           reg_written;
    logic [RSW-1:0] dest_register;
    logic [DW-1:0]  dest_value;
    logic           mem_written;
    logic [WAW-1:0] store_address;
    logic [DW-1:0]  store_value;
    logic [DW-1:0]  read_value;
    logic           halted_now;
  } out_rsp_t;

endpackage

FILE: rtl/core/trop_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Core channel interfaces
// Valid/ready channels for host requests and for results.
// ---------------------------------------------------------------------------
interface trop_in_if import trop_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OPW-1:0]        operation;
  logic [WAW-1:0]        word_address;
  logic signed [DW-1:0]  load_value;
  logic [RSW-1:0]        register_select;

  modport source(output valid, output operation, output word_address,
                 output load_value, output register_select, input ready);
  modport sink(input valid, input operation, input word_address,
               input load_value, input register_select, output ready);
endinterface

interface trop_out_if import trop_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STW-1:0]        status;
  logic [WAW-1:0]        executed_pc;
  logic                  reg_written;
  logic [RSW-1:0]        dest_register;
  logic signed [DW-1:0]  dest_value;
  logic                  mem_written;
  logic [WAW-1:0]        store_address;
  logic signed [DW-1:0]  store_value;
  logic signed [DW-1:0]  read_value;
  logic                  halted_now;

  modport source(output valid, output status, output executed_pc,
                 output reg_written, output dest_register, output dest_value,
                 output mem_written, output store_address, output store_value,
                 output read_value, output halted_now, input ready);
  modport sink(input valid, input status, input executed_pc,
               input reg_written, input dest_register, input dest_value,
               input mem_written, input store_address, input store_value,
               input read_value, input halted_now, output ready);
endinterface

FILE: rtl/core/trop_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module trop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/trop_regfile.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Register file
// RAM-backed register bank with per-entry valid bits; an entry not written
// since reset reads as zero, so R0 (never written) always reads zero.
// ---------------------------------------------------------------------------
module trop_regfile import trop_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           we,
  input  logic [RAW-1:0] waddr,
  input  logic [DW-1:0]  wdata,
  input  logic [RAW-1:0] raddr,
  output logic [DW-1:0]  rdata
);

  logic [REG_COUNT-1:0] vld_r;
  logic                 rd_vld_r;
  logic [DW-1:0]        ram_q;

  trop_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Mark written entries; reset clears every mark at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Track the valid bit alongside the registered read
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[raddr];
  end

  assign rdata = rd_vld_r ? ram_q : '0;

endmodule

FILE: rtl/core/trop_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared ALU
// One adder, one 32x32 low-word multiplier, logic ops and shifts; used for
// results, data addresses, branch compares and next-pc computation.
// ---------------------------------------------------------------------------
module trop_alu import trop_pkg::*; (
  input  alu_req_t      req,
  output logic [DW-1:0] result
);

  logic [DW-1:0] b_eff;
  logic          cin;
  logic [DW-1:0] sum;
  logic          shift_big;

  // Adder shared by add, subtract and increment-add
  assign b_eff     = (req.fn == ALU_SUB) ? ~req.b : req.b;
  assign cin       = (req.fn == ALU_SUB) || (req.fn == ALU_INC);
  assign sum       = req.a + b_eff + DW'(cin);
  assign shift_big = (req.b >= DW'(DW));

  // Select the function result
  always_comb begin
    case (req.fn)
      ALU_ADD, ALU_SUB, ALU_INC: result = sum;
      ALU_MUL: result = req.a * req.b;
      ALU_AND: result = req.a & req.b;
      ALU_OR:  result = req.a | req.b;
      ALU_SLL: result = shift_big ? '0 : (req.a << req.b[4:0]);
      ALU_SRL: result = shift_big ? '0 : (req.a >> req.b[4:0]);
      default: result = '0;
    endcase
  end

endmodule

FILE: rtl/core/twelve_op_risc_processor_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Twelve-op RISC processor core
// Host-driven 32-bit core: shared word memory, 32 registers, one shared ALU
// stepped by a multi-cycle sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one host request: load a memory word, execute one
//   instruction, read a memory word, read a register, or restart. out_chan
//   returns exactly one result per request, in order.
//   A request is taken only while the sequencer is idle; one request is in
//   flight at a time. An execute steps through fetch, decode, two register
//   reads, execute, a memory access for LW and SW, a write-back of the loaded
//   word for LW, and next pc; a halted core or a zero instruction ends early.
//   The result turns valid as the sequencer returns to idle and can take the
//   next request. The steps are set by the word memory and register file,
//   each with one read port reading one word per cycle, and the one ALU used
//   for the result and again for the next pc. The result sits in an output
//   register; when the receiver stalls, the finished result waits there and
//   the next request is still accepted and worked on, holding in its final
//   step until the register frees up. Reset clears pc, halt flag and register
//   valid bits at once, then a clearing pass writes zero to all MEM_WORDS
//   memory words with in_chan not ready. MEM_WORDS must be a power of two.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module twelve_op_risc_processor_core import trop_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  trop_in_if.sink   in_chan,
  trop_out_if.source out_chan
);

  localparam int AW = $clog2(MEM_WORDS);

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HLOAD  = 4'd2;
  localparam logic [3:0] S_HRD    = 4'd3;
  localparam logic [3:0] S_HRDW   = 4'd4;
  localparam logic [3:0] S_RRD    = 4'd5;
  localparam logic [3:0] S_RRDW   = 4'd6;
  localparam logic [3:0] S_FETCH  = 4'd7;
  localparam logic [3:0] S_DECODE = 4'd8;
  localparam logic [3:0] S_RDA    = 4'd9;
  localparam logic [3:0] S_RDB    = 4'd10;
  localparam logic [3:0] S_EXE    = 4'd11;
  localparam logic [3:0] S_MEM    = 4'd12;
  localparam logic [3:0] S_LWB    = 4'd13;
  localparam logic [3:0] S_NPC    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] pc_r, pc_nxt;
  logic          halt_r, halt_nxt;
  logic          out_valid_r, out_valid_nxt;
  in_req_t       req_r, req_nxt;
  logic [DW-1:0] ins_r, ins_nxt;
  logic [DW-1:0] a_r, a_nxt;
  logic [DW-1:0] b_r, b_nxt;
  logic [DW-1:0] res_r, res_nxt;
  out_rsp_t      rsp_r, rsp_nxt;
  out_rsp_t      out_r, out_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic           rf_we;
  logic [RAW-1:0] rf_waddr;
  logic [DW-1:0]  rf_wdata;
  logic [RAW-1:0] rf_raddr;
  logic [DW-1:0]  rf_rdata;

  alu_req_t      alu_req;
  logic [DW-1:0] alu_res;

  logic           in_acc;
  logic [3:0]     opc;
  logic [RSW-1:0] r1;
  logic [RSW-1:0] r3;
  logic [DW-1:0]  imm;
  logic           wr_op;
  logic [AW-1:0]  haddr;
  logic           hwrap;
  logic [AW-1:0]  daddr;
  logic           dwrap;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  // Decode the latched instruction word
  assign opc   = ins_r[31:28];
  assign r1    = ins_r[27:23];
  assign r3    = ins_r[17:13];
  assign imm   = {{(DW-IMM_W){ins_r[IMM_W-1]}}, ins_r[IMM_W-1:0]};
  assign wr_op = opc inside {OP_ADD, OP_SUB, OP_MULI, OP_ADDI, OP_ANDI, OP_ORI,
                             OP_SLL, OP_SRL, OP_LW};

  // Host and data addresses, wrapped to the memory size
  assign haddr = AW'(req_r.word_address);
  assign hwrap = (DW'(req_r.word_address) >= DW'(MEM_WORDS));
  assign daddr = res_r[AW-1:0];
  assign dwrap = (res_r >= DW'(MEM_WORDS));

  trop_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  trop_regfile u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  trop_alu u_alu (
    .req    (alu_req),
    .result (alu_res)
  );

  // Steer the shared ALU by sequencer step
  always_comb begin
    alu_req.fn = ALU_ADD;
    alu_req.a  = a_r;
    alu_req.b  = imm;
    case (state_r)
      S_EXE: begin
        case (opc)
          OP_ADD:  alu_req.b = b_r;
          OP_SUB: begin
            alu_req.fn = ALU_SUB;
            alu_req.b  = b_r;
          end
          OP_MULI: alu_req.fn = ALU_MUL;
          OP_BNE: begin
            alu_req.fn = ALU_SUB;
            alu_req.a  = b_r;
            alu_req.b  = a_r;
          end
          OP_ANDI: alu_req.fn = ALU_AND;
          OP_ORI:  alu_req.fn = ALU_OR;
          OP_SLL: begin
            alu_req.fn = ALU_SLL;
            alu_req.b  = DW'(ins_r[SHW-1:0]);
          end
          OP_SRL: begin
            alu_req.fn = ALU_SRL;
            alu_req.b  = DW'(ins_r[SHW-1:0]);
          end
          default: alu_req.fn = ALU_ADD;
        endcase
      end
      S_NPC: begin
        alu_req.fn = ALU_INC;
        alu_req.a  = DW'(pc_r);
        alu_req.b  = ((opc == OP_BNE) && (res_r != '0)) ? imm : '0;
      end
      default: alu_req.fn = ALU_ADD;
    endcase
  end

  // Sequencer: next state, memory and register file ports, result build
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    ins_nxt       = ins_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    rsp_nxt       = rsp_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = haddr;
    mem_wdata     = req_r.load_value;
    mem_raddr     = pc_r;
    rf_we         = 1'b0;
    rf_waddr      = r1;
    rf_wdata      = res_r;
    rf_raddr      = mem_rdata[22:18];

    // Drop the result once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_nxt.operation       = in_chan.operation;
          req_nxt.word_address    = in_chan.word_address;
          req_nxt.load_value      = in_chan.load_value;
          req_nxt.register_select = in_chan.register_select;
          rsp_nxt = '0;
          case (in_chan.operation)
            HOP_LOAD:  state_nxt = S_HLOAD;
            HOP_EXEC: begin
              if (halt_r) begin
                rsp_nxt.status = ST_HALTED;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            HOP_RDMEM: state_nxt = S_HRD;
            HOP_RDREG: state_nxt = S_RRD;
            HOP_RESTART: begin
              pc_nxt    = '0;
              halt_nxt  = 1'b0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_HLOAD: begin
        mem_we = 1'b1;
        if (hwrap) begin
          rsp_nxt.status = ST_WRAP;
        end
        state_nxt = S_DONE;
      end
      S_HRD: begin
        mem_raddr = haddr;
        if (hwrap) begin
          rsp_nxt.status = ST_WRAP;
        end
        state_nxt = S_HRDW;
      end
      S_HRDW: begin
        rsp_nxt.read_value = mem_rdata;
        state_nxt          = S_DONE;
      end
      S_RRD: begin
        rf_raddr  = req_r.register_select;
        state_nxt = S_RRDW;
      end
      S_RRDW: begin
        rsp_nxt.read_value = rf_rdata;
        state_nxt          = S_DONE;
      end
      S_FETCH: begin
        mem_raddr           = pc_r;
        rsp_nxt.executed_pc = WAW'(pc_r);
        state_nxt           = S_DECODE;
      end
      S_DECODE: begin
        // Zero word halts; otherwise start the first operand read
        ins_nxt  = mem_rdata;
        rf_raddr = mem_rdata[22:18];
        if (mem_rdata == '0) begin
          halt_nxt       = 1'b1;
          rsp_nxt.status = ST_HALTED;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        a_nxt     = rf_rdata;
        rf_raddr  = ((opc == OP_BNE) || (opc == OP_SW)) ? r1 : r3;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        b_nxt     = rf_rdata;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        res_nxt = alu_res;
        if ((opc == OP_LW) || (opc == OP_SW)) begin
          state_nxt = S_MEM;
        end else begin
          state_nxt = S_NPC;
        end
      end
      S_MEM: begin
        mem_raddr = daddr;
        if (dwrap) begin
          rsp_nxt.status = ST_WRAP;
        end
        if (opc == OP_SW) begin
          mem_we                = 1'b1;
          mem_waddr             = daddr;
          mem_wdata             = b_r;
          rsp_nxt.mem_written   = 1'b1;
          rsp_nxt.store_address = WAW'(daddr);
          rsp_nxt.store_value   = b_r;
          state_nxt             = S_NPC;
        end else begin
          state_nxt = S_LWB;
        end
      end
      S_LWB: begin
        res_nxt   = mem_rdata;
        state_nxt = S_NPC;
      end
      S_NPC: begin
        // Advance pc and write back the destination register
        pc_nxt = (opc == OP_J) ? ins_r[AW-1:0] : alu_res[AW-1:0];
        if (wr_op && (r1 != '0)) begin
          rf_we                 = 1'b1;
          rsp_nxt.reg_written   = 1'b1;
          rsp_nxt.dest_register = r1;
          rsp_nxt.dest_value    = res_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_nxt            = rsp_r;
          out_nxt.halted_now = halt_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    ins_r <= ins_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
    rsp_r <= rsp_nxt;
    out_r <= out_nxt;
  end

  // Drive the result channel
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_r.status;
  assign out_chan.executed_pc   = out_r.executed_pc;
  assign out_chan.reg_written   = out_r.reg_written;
  assign out_chan.dest_register = out_r.dest_register;
  assign out_chan.dest_value    = out_r.dest_value;
  assign out_chan.mem_written   = out_r.mem_written;
  assign out_chan.store_address = out_r.store_address;
  assign out_chan.store_value   = out_r.store_value;
  assign out_chan.read_value    = out_r.read_value;
  assign out_chan.halted_now    = out_r.halted_now;

  // Checks
  `ASSERT_CLK(a_rst_clear, clk, !rst_n |=> (state_r == S_CLEAR && !out_valid_r), "reset did not start the clearing pass")
  `ASSERT_CLKRST(a_one_in_flight, clk, rst_n, in_acc |=> !in_chan.ready, "request accepted while busy")
  `ASSERT_CLKRST(a_mem_we_src, clk, rst_n, mem_we |-> (state_r == S_CLEAR || state_r == S_HLOAD || state_r == S_MEM), "memory written outside clear load or store")
  `ASSERT_CLKRST(a_no_r0_write, clk, rst_n, rf_we |-> (rf_waddr != '0), "write to R0")
  `ASSERT_CLKRST(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_DONE), "result raised outside final step")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Twelve-op RISC core testbench
// Loads short random programs into the shared word memory, restarts the core,
// single-steps it and reads back registers and memory. A built-in golden
// model of the core predicts every result, and the results are compared in
// order. Both channels idle at random. A watchdog ends a stuck run.
// ---------------------------------------------------------------------------
module testbench;
  import trop_pkg::*;

  localparam int HOST_ITEMS_GOAL = 650;
  localparam int WATCHDOG_CYCLES = 6000;  // covers the memory clearing pass
  localparam int END_SLACK       = 20;
  localparam int MAX_REPORTS     = 10;

  // Operation codes the core ignores, and an opcode with no instruction
  localparam logic [OPW-1:0] HOP_SPARE_LO = 3'd5;
  localparam logic [OPW-1:0] HOP_SPARE_HI = 3'd7;
  localparam logic [3:0]     OP_SPARE     = 4'd15;

  typedef struct packed {
    logic    hold;  // wait for all outstanding results before sending
    in_req_t req;
  } pend_t;

  logic clk = 1'b0;
  logic rst_n;

  trop_in_if  in_chan ();
  trop_out_if out_chan ();

  twelve_op_risc_processor_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Golden copy of the core state
  logic [DW-1:0]  mem_model [MEM_WORDS_DEF];
  logic [DW-1:0]  reg_model [REG_COUNT];
  logic [WAW-1:0] pc_model;
  logic           halt_model;

  pend_t    pending_reqs [$];
  out_rsp_t expected_results [$];

  int  host_items;
  bit  hold_next;
  int  accepted_cnt, checked_cnt, mismatches;
  int  retired_cnt, store_cnt, wrap_cnt, halt_cnt;
  int  quiet_cycles;

  // -------------------------------------------------------------------------
  // Golden model: apply one host request, return the result it produces
  // -------------------------------------------------------------------------
  function automatic out_rsp_t predict_step(in_req_t req);
    out_rsp_t       r;
    logic [DW-1:0]  ins, a, res, imm, ea, v;
    logic [WAW-1:0] nxt;
    logic [4:0]     rd;
    logic [3:0]     opc;
    logic [SHW-1:0] sh;
    logic           wr;
    r = '0;
    case (req.operation)
      HOP_LOAD: mem_model[req.word_address] = req.load_value;
      HOP_EXEC: begin
        if (halt_model) begin
          r.status = ST_HALTED;
        end else begin
          ins = mem_model[pc_model];
          r.executed_pc = pc_model;
          if (ins == '0) begin
            // zero word: halt in place
            halt_model = 1'b1;
            r.status = ST_HALTED;
          end else begin
            opc = ins[31:28];
            rd  = ins[27:23];
            a   = reg_model[ins[22:18]];
            imm = {{(DW-IMM_W){ins[IMM_W-1]}}, ins[IMM_W-1:0]};
            sh  = ins[SHW-1:0];
            nxt = pc_model + 11'd1;
            wr  = 1'b0;
            res = '0;
            case (opc)
              OP_ADD:  begin res = a + reg_model[ins[17:13]]; wr = 1'b1; end
              OP_SUB:  begin res = a - reg_model[ins[17:13]]; wr = 1'b1; end
              OP_MULI: begin res = a * imm; wr = 1'b1; end
              OP_ADDI: begin res = a + imm; wr = 1'b1; end
              OP_ANDI: begin res = a & imm; wr = 1'b1; end
              OP_ORI:  begin res = a | imm; wr = 1'b1; end
              OP_BNE: begin
                if (reg_model[rd] != a) nxt = pc_model + 11'd1 + imm[WAW-1:0];
              end
              OP_J: nxt = ins[WAW-1:0];
              OP_SLL: begin res = (sh >= 13'd32) ? '0 : (a << sh[4:0]); wr = 1'b1; end
              OP_SRL: begin res = (sh >= 13'd32) ? '0 : (a >> sh[4:0]); wr = 1'b1; end
              OP_LW: begin
                ea = a + imm;
                if (ea[DW-1:WAW] != '0) r.status = ST_WRAP;
                res = mem_model[ea[WAW-1:0]];
                wr = 1'b1;
              end
              OP_SW: begin
                ea = a + imm;
                if (ea[DW-1:WAW] != '0) r.status = ST_WRAP;
                v = reg_model[rd];
                mem_model[ea[WAW-1:0]] = v;
                r.mem_written   = 1'b1;
                r.store_address = ea[WAW-1:0];
                r.store_value   = v;
              end
              default: ;
            endcase
            // R0 is never written
            if (wr && rd != 5'd0) begin
              reg_model[rd]   = res;
              r.reg_written   = 1'b1;
              r.dest_register = rd;
              r.dest_value    = res;
            end
            pc_model = nxt;
          end
        end
      end
      HOP_RDMEM: r.read_value = mem_model[req.word_address];
      HOP_RDREG: r.read_value = reg_model[req.register_select];
      HOP_RESTART: begin
        pc_model   = '0;
        halt_model = 1'b0;
      end
      default: ;
    endcase
    r.halted_now = halt_model;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic [WAW-1:0] rnd_addr();
    return WAW'($urandom);
  endfunction

  function automatic logic [DW-1:0] rnd_word();
    return $urandom;
  endfunction

  function automatic logic [RSW-1:0] rnd_reg();
    return RSW'($urandom);
  endfunction

  // Mostly low registers so that instructions depend on each other
  function automatic logic [RSW-1:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? RSW'($urandom) : RSW'($urandom_range(0, 7));
  endfunction

  // Data words mostly sit in a window clear of the program
  function automatic logic [WAW-1:0] data_addr();
    return ($urandom_range(0, 9) < 7) ? WAW'($urandom_range(64, 127)) : rnd_addr();
  endfunction

  function automatic logic [DW-1:0] mk_insn(logic [3:0] opc, logic [4:0] r1, logic [4:0] r2,
                                            logic [IMM_W-1:0] low);
    return {opc, r1, r2, low};
  endfunction

  // Random instruction for a program of prog_len words at address zero
  function automatic logic [DW-1:0] rand_insn(int prog_len);
    logic [3:0]       opc;
    logic [4:0]       rd, rs;
    logic [IMM_W-1:0] low;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    opc = (r < 10) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
    rd  = pick_reg();
    rs  = pick_reg();
    low = IMM_W'($urandom);
    case (opc)
      OP_ADD, OP_SUB: low = {pick_reg(), SHW'($urandom)};
      OP_SLL, OP_SRL: begin
        low = {pick_reg(), ($urandom_range(0, 4) == 0) ? SHW'($urandom_range(32, 8191))
                                                       : SHW'($urandom_range(0, 31))};
      end
      OP_BNE: low = IMM_W'($urandom_range(0, 6)) - IMM_W'(3);
      OP_J: begin
        return {OP_J, ($urandom_range(0, 1) == 0) ? 17'($urandom) : 17'd0,
                WAW'($urandom_range(0, prog_len - 1))};
      end
      OP_LW, OP_SW: begin
        if ($urandom_range(0, 3) != 0) begin
          rs  = 5'd0;
          low = IMM_W'($urandom_range(64, 127));
        end
      end
      default: begin
        if ($urandom_range(0, 1) == 0) low = IMM_W'($urandom_range(0, 64)) - IMM_W'(32);
      end
    endcase
    return {opc, rd, rs, low};
  endfunction

  task automatic send(logic [OPW-1:0] op, logic [WAW-1:0] addr, logic [DW-1:0] val,
                      logic [RSW-1:0] rsel);
    pend_t p;
    p.hold                = hold_next;
    p.req.operation       = op;
    p.req.word_address    = addr;
    p.req.load_value      = val;
    p.req.register_select = rsel;
    hold_next = 1'b0;
    pending_reqs.push_back(p);
    if (op <= HOP_RESTART) host_items++;
  endtask

  task automatic send_op(logic [OPW-1:0] op);
    send(op, rnd_addr(), rnd_word(), rnd_reg());
  endtask

  // Hand-picked program: all-ones value, wide shift, wrapping store, unused
  // opcode, wrapping jump, write to R0, halt on a zero word
  task automatic add_directed();
    send(HOP_LOAD, WAW'(0), mk_insn(OP_ADDI, 5'd1, 5'd0, 18'h3FFFF), rnd_reg());
    send(HOP_LOAD, WAW'(1), mk_insn(OP_SLL, 5'd2, 5'd1, {5'd0, 13'd40}), rnd_reg());
    send(HOP_LOAD, WAW'(2), mk_insn(OP_SW, 5'd1, 5'd1, 18'd0), rnd_reg());
    send(HOP_LOAD, WAW'(3), mk_insn(OP_SPARE, 5'd31, 5'd31, 18'h3FFFF), rnd_reg());
    send(HOP_LOAD, WAW'(4), {OP_J, 28'hFFFF805}, rnd_reg());
    send(HOP_LOAD, WAW'(5), mk_insn(OP_ADD, 5'd0, 5'd1, {5'd1, 13'd0}), rnd_reg());
    // word 6 is still zero: the seventh step halts, the eighth finds it halted
    repeat (8) send_op(HOP_EXEC);
    send(HOP_RDMEM, WAW'(2047), rnd_word(), rnd_reg());
    send(HOP_RDREG, rnd_addr(), rnd_word(), 5'd1);
    send(HOP_RDREG, rnd_addr(), rnd_word(), 5'd31);
    send(HOP_RDREG, rnd_addr(), rnd_word(), 5'd0);
    send_op(HOP_SPARE_LO);
    send_op(HOP_SPARE_HI);
    send_op(HOP_RESTART);
    send(HOP_LOAD, WAW'(2047), 32'h8000_0000, rnd_reg());
    send(HOP_RDMEM, WAW'(2047), rnd_word(), rnd_reg());
    send_op(HOP_EXEC);
  endtask

  // Load a short program, restart and step through it with reads mixed in
  task automatic add_program();
    int len, runs, i;
    len = $urandom_range(3, 10);
    for (i = 0; i < len; i++) send(HOP_LOAD, WAW'(i), rand_insn(len), rnd_reg());
    if ($urandom_range(0, 1) == 0) send(HOP_LOAD, WAW'(len), '0, rnd_reg());
    if ($urandom_range(0, 2) == 0) send(HOP_LOAD, data_addr(), rnd_word(), rnd_reg());
    send_op(HOP_RESTART);
    runs = $urandom_range(len, 2 * len + 3);
    for (i = 0; i < runs; i++) begin
      send_op(HOP_EXEC);
      case ($urandom_range(0, 11))
        0: send(HOP_RDREG, rnd_addr(), rnd_word(), pick_reg());
        1: send(HOP_RDMEM, data_addr(), rnd_word(), rnd_reg());
        2: send(HOP_RDMEM, WAW'($urandom_range(0, len)), rnd_word(), rnd_reg());
        3: if ($urandom_range(0, 3) == 0) send_op(HOP_RESTART);
        default: ;
      endcase
    end
    for (i = 1; i < REG_COUNT; i += $urandom_range(1, 6))
      send(HOP_RDREG, rnd_addr(), rnd_word(), RSW'(i));
  endtask

  // Unstructured requests, spare operation codes included
  task automatic add_noise();
    int n, i;
    n = $urandom_range(3, 8);
    for (i = 0; i < n; i++) send(OPW'($urandom_range(0, 7)), rnd_addr(), rnd_word(), rnd_reg());
  endtask

  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Driver: present queued requests, predict each one as it is accepted
  // -------------------------------------------------------------------------
  pend_t   cur_pend;
  in_req_t cur_req;
  int      send_gap;
  bit      send_steady;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_results.push_back(predict_step(cur_req));
        accepted_cnt++;
        if (cur_req.operation == HOP_EXEC) begin
          if (expected_results[$].status != ST_HALTED) retired_cnt++;
          if (expected_results[$].status == ST_WRAP) wrap_cnt++;
          if (expected_results[$].mem_written) store_cnt++;
          if (expected_results[$].status == ST_HALTED) halt_cnt++;
        end
      end
      if ($urandom_range(0, 59) == 0) send_steady = !send_steady;
      // advance only when the bus is free or the request just went through
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold && expected_results.size() != 0)) begin
          cur_pend = pending_reqs.pop_front();
          cur_req  = cur_pend.req;
          in_chan.operation       <= cur_req.operation;
          in_chan.word_address    <= cur_req.word_address;
          in_chan.load_value      <= cur_req.load_value;
          in_chan.register_select <= cur_req.register_select;
          in_chan.valid           <= 1'b1;
          send_gap = (send_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: random backpressure, compare each result with the oldest
  // prediction
  // -------------------------------------------------------------------------
  int recv_stall;
  bit recv_steady;

  function automatic string fmt_rsp(out_rsp_t r);
    return $sformatf("st=%0d pc=%0d rw=%0b rd=%0d dv=%h mw=%0b sa=%0d sv=%h rv=%h h=%0b",
                     r.status, r.executed_pc, r.reg_written, r.dest_register, r.dest_value,
                     r.mem_written, r.store_address, r.store_value, r.read_value,
                     r.halted_now);
  endfunction

  task automatic check_result();
    out_rsp_t got, want;
    got.status        = out_chan.status;
    got.executed_pc   = out_chan.executed_pc;
    got.reg_written   = out_chan.reg_written;
    got.dest_register = out_chan.dest_register;
    got.dest_value    = out_chan.dest_value;
    got.mem_written   = out_chan.mem_written;
    got.store_address = out_chan.store_address;
    got.store_value   = out_chan.store_value;
    got.read_value    = out_chan.read_value;
    got.halted_now    = out_chan.halted_now;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] result with no request outstanding: %s", $realtime, fmt_rsp(got));
    end else begin
      want = expected_results.pop_front();
      checked_cnt++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] mismatch on result %0d", $realtime, checked_cnt);
          $display("  expected %s", fmt_rsp(want));
          $display("  actual   %s", fmt_rsp(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_result();
      if ($urandom_range(0, 79) == 0) recv_steady = !recv_steady;
      if (recv_stall > 0) begin
        recv_stall--;
        out_chan.ready <= 1'b0;
      end else if (!recv_steady && $urandom_range(0, 4) == 0) begin
        recv_stall = idle_len() - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either channel
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_CYCLES, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence: build the request list, release reset, wait for drain
  // -------------------------------------------------------------------------
  initial begin
    in_chan.valid           = 1'b0;
    in_chan.operation       = '0;
    in_chan.word_address    = '0;
    in_chan.load_value      = '0;
    in_chan.register_select = '0;
    out_chan.ready          = 1'b0;
    rst_n                   = 1'b0;
    quiet_cycles            = 0;
    foreach (mem_model[i]) mem_model[i] = '0;
    foreach (reg_model[i]) reg_model[i] = '0;
    pc_model   = '0;
    halt_model = 1'b0;

    add_directed();
    // drain everything once before the random part starts
    hold_next = 1'b1;
    while (host_items < HOST_ITEMS_GOAL) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_program();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_chan.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (END_SLACK) @(posedge clk);

    $display("Covered %0d requests: %0d instructions retired, %0d stores, %0d wraps, %0d halts",
             accepted_cnt, retired_cnt, store_cnt, wrap_cnt, halt_cnt);
    $display("Checked %0d results, %0d mismatches", checked_cnt, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: twelve_op_risc_processor_core.f
+incdir+rtl/core
rtl/core/trop_pkg.sv
rtl/core/trop_ifs.sv
rtl/core/trop_ram.sv
rtl/core/trop_regfile.sv
rtl/core/trop_alu.sv
rtl/core/twelve_op_risc_processor_core.sv
verif/testbench.sv
